@@ rtl/fqd_pkg.sv @@
// Package for the FIFO queue with delete-by-value.
// Command and status codes plus the fixed payload types; no dependencies.
package fqd_pkg;

	localparam int CMD_W    = 3;
	localparam int VALUE_W  = 32;
	localparam int STATUS_W = 2;

	typedef logic [CMD_W-1:0]           cmd_t;
	typedef logic [STATUS_W-1:0]        status_t;
	typedef logic signed [VALUE_W-1:0]  value_t;

	localparam cmd_t CMD_ENQ  = 3'd0;
	localparam cmd_t CMD_DEQ  = 3'd1;
	localparam cmd_t CMD_PEEK = 3'd2;
	localparam cmd_t CMD_CLR  = 3'd3;
	localparam cmd_t CMD_DEL  = 3'd4;

	localparam status_t STAT_OK       = 2'd0;
	localparam status_t STAT_EMPTY    = 2'd1;
	localparam status_t STAT_FULL     = 2'd2;
	localparam status_t STAT_NOTFOUND = 2'd3;

endpackage

@@ rtl/fqd_if.sv @@
// Valid/ready channel interfaces for the command and result beats.
// Depends on fqd_pkg.
interface fqd_in_if;
	import fqd_pkg::*;

	logic   valid;
	logic   ready;
	cmd_t   cmd;
	value_t value;

	modport source (output valid, cmd, value, input ready);
	modport sink   (input valid, cmd, value, output ready);
endinterface

interface fqd_out_if #(parameter int CNT_W = 5);
	import fqd_pkg::*;

	logic             valid;
	logic             ready;
	status_t          status;
	value_t           data;
	logic [CNT_W-1:0] count;
	logic             empty_res;

	modport source (output valid, status, data, count, empty_res, input ready);
	modport sink   (input valid, status, data, count, empty_res, output ready);
endinterface

@@ rtl/fifo_queue_with_delete.sv @@
// Bounded FIFO of signed words kept in a DEPTH-entry ring buffer in one
// synchronous RAM, with a head pointer and an entry count in flip-flops.
// Commands (enqueue, dequeue, peek, clear, delete first match) are taken one
// at a time and each gives one result beat. Enqueue, clear, unused codes and
// refused commands go from the command beat straight to the finish state,
// peek and dequeue through the read state first, and the result register
// loads from the finish state once the output is free; delete scans the queue
// from the head at one entry a cycle and then compacts the entries behind the
// match at one entry a cycle, both limited by the single read port of the RAM.
// The next command beat is taken the cycle after the result register loads,
// so the result register lets it in while the last result waits.
// Depends on fqd_pkg, fqd_if, fqd_ram and fqd_ctrl.
module fifo_queue_with_delete #(
	parameter int DEPTH      = 16,
	parameter int DATA_WIDTH = 32
) (
	input  logic      clk,
	input  logic      arst_n,
	fqd_in_if.sink    req,
	fqd_out_if.source rsp
);
	import fqd_pkg::*;

	localparam int AW = $clog2(DEPTH);

	logic                  mem_we;
	logic [AW-1:0]         mem_waddr;
	logic [DATA_WIDTH-1:0] mem_wdata;
	logic                  mem_re;
	logic [AW-1:0]         mem_raddr;
	logic [DATA_WIDTH-1:0] mem_rdata;

	fqd_ram #(
		.DEPTH (DEPTH),
		.WIDTH (DATA_WIDTH)
	) u_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	fqd_ctrl #(
		.DEPTH      (DEPTH),
		.DATA_WIDTH (DATA_WIDTH)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.rsp       (rsp),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata),
		.mem_re    (mem_re),
		.mem_raddr (mem_raddr),
		.mem_rdata (mem_rdata)
	);

endmodule

@@ rtl/fqd_ram.sv @@
// Entry store: simple dual-port RAM, one write and one registered read port.
// No package dependencies.
module fqd_ram #(
	parameter int DEPTH = 16,
	parameter int WIDTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ rtl/fqd_ctrl.sv @@
// Command sequencer: ring pointers, search and compaction, result register.
// Depends on fqd_pkg and fqd_if; drives the ports of fqd_ram.
module fqd_ctrl #(
	parameter int DEPTH      = 16,
	parameter int DATA_WIDTH = 32
) (
	input  logic                     clk,
	input  logic                     arst_n,
	fqd_in_if.sink                   req,
	fqd_out_if.source                rsp,
	output logic                     mem_we,
	output logic [$clog2(DEPTH)-1:0] mem_waddr,
	output logic [DATA_WIDTH-1:0]    mem_wdata,
	output logic                     mem_re,
	output logic [$clog2(DEPTH)-1:0] mem_raddr,
	input  logic [DATA_WIDTH-1:0]    mem_rdata
);
	import fqd_pkg::*;

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_READ  = 3'd1;
	localparam logic [2:0] S_SCAN  = 3'd2;
	localparam logic [2:0] S_SHIFT = 3'd3;
	localparam logic [2:0] S_FIN   = 3'd4;

	logic [2:0]            state_q;
	logic [AW-1:0]         head_q;
	logic [CW-1:0]         count_q;
	cmd_t                  cmd_q;
	logic [DATA_WIDTH-1:0] word_q;
	logic [CW-1:0]         rd_i_q;
	logic                  cmp_v_q;
	logic [CW-1:0]         cmp_i_q;
	logic                  wv_q;
	logic [CW-1:0]         wj_q;
	status_t               res_status_q;
	value_t                res_data_q;
	logic                  ov_q;
	status_t               out_status_q;
	value_t                out_data_q;
	logic [CW-1:0]         out_count_q;
	logic                  out_empty_q;

	logic                  acc;
	logic                  full;
	logic                  empty;
	logic                  rd_more;
	logic                  out_free;
	logic [DATA_WIDTH-1:0] word_in;

	// Ring position of an offset from the head; the sum stays below twice DEPTH.
	function automatic logic [AW-1:0] slot(input logic [AW-1:0] base, input logic [CW-1:0] off);
		logic [CW:0] s;
		s = (CW+1)'(base) + (CW+1)'(off);
		if (s >= (CW+1)'(DEPTH)) s = s - (CW+1)'(DEPTH);
		return s[AW-1:0];
	endfunction

	assign req.ready = (state_q == S_IDLE);
	assign acc       = req.valid && req.ready;
	assign full      = (count_q == CW'(DEPTH));
	assign empty     = (count_q == '0);
	assign rd_more   = (rd_i_q < count_q);
	assign out_free  = !ov_q || rsp.ready;
	assign word_in   = DATA_WIDTH'(req.value);

	assign rsp.valid     = ov_q;
	assign rsp.status    = out_status_q;
	assign rsp.data      = out_data_q;
	assign rsp.count     = out_count_q;
	assign rsp.empty_res = out_empty_q;

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = slot(head_q, count_q);
		mem_wdata = word_in;
		mem_re    = 1'b0;
		mem_raddr = head_q;
		case (state_q)
			S_IDLE: begin
				if (acc) begin
					case (req.cmd)
						CMD_ENQ:           mem_we = !full;
						CMD_DEQ, CMD_PEEK: mem_re = !empty;
						default: ;
					endcase
				end
			end
			S_SCAN: begin
				mem_re    = rd_more;
				mem_raddr = slot(head_q, rd_i_q);
			end
			S_SHIFT: begin
				// read the entry behind, write it one place forward in the following cycle
				mem_re    = rd_more;
				mem_raddr = slot(head_q, rd_i_q);
				mem_we    = wv_q;
				mem_waddr = slot(head_q, wj_q);
				mem_wdata = mem_rdata;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			head_q       <= '0;
			count_q      <= '0;
			cmd_q        <= CMD_ENQ;
			word_q       <= '0;
			rd_i_q       <= '0;
			cmp_v_q      <= 1'b0;
			cmp_i_q      <= '0;
			wv_q         <= 1'b0;
			wj_q         <= '0;
			res_status_q <= STAT_OK;
			res_data_q   <= '0;
			ov_q         <= 1'b0;
			out_status_q <= STAT_OK;
			out_data_q   <= '0;
			out_count_q  <= '0;
			out_empty_q  <= 1'b1;
		end else begin
			if (state_q == S_FIN && out_free) begin
				ov_q <= 1'b1;
			end else if (rsp.ready) begin
				ov_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (acc) begin
						cmd_q      <= req.cmd;
						word_q     <= word_in;
						res_data_q <= '0;
						case (req.cmd)
							CMD_ENQ: begin
								state_q <= S_FIN;
								if (full) begin
									res_status_q <= STAT_FULL;
								end else begin
									res_status_q <= STAT_OK;
									count_q      <= count_q + CW'(1);
								end
							end
							CMD_DEQ, CMD_PEEK: begin
								if (empty) begin
									res_status_q <= STAT_EMPTY;
									state_q      <= S_FIN;
								end else begin
									res_status_q <= STAT_OK;
									state_q      <= S_READ;
								end
							end
							CMD_CLR: begin
								res_status_q <= STAT_OK;
								head_q       <= '0;
								count_q      <= '0;
								state_q      <= S_FIN;
							end
							CMD_DEL: begin
								if (empty) begin
									res_status_q <= STAT_NOTFOUND;
									state_q      <= S_FIN;
								end else begin
									res_status_q <= STAT_OK;
									rd_i_q       <= '0;
									cmp_v_q      <= 1'b0;
									state_q      <= S_SCAN;
								end
							end
							default: begin
								res_status_q <= STAT_OK;
								state_q      <= S_FIN;
							end
						endcase
					end
				end
				S_READ: begin
					res_data_q <= VALUE_W'(mem_rdata);
					if (cmd_q == CMD_DEQ) begin
						head_q  <= slot(head_q, CW'(1));
						count_q <= count_q - CW'(1);
					end
					state_q <= S_FIN;
				end
				S_SCAN: begin
					cmp_i_q <= rd_i_q;
					if (cmp_v_q && mem_rdata == word_q) begin
						// match: close the gap starting with the entry behind it
						rd_i_q  <= cmp_i_q + CW'(1);
						cmp_v_q <= 1'b0;
						wv_q    <= 1'b0;
						state_q <= S_SHIFT;
					end else begin
						if (rd_more) begin
							rd_i_q <= rd_i_q + CW'(1);
						end
						if (cmp_v_q && cmp_i_q == count_q - CW'(1)) begin
							cmp_v_q      <= 1'b0;
							res_status_q <= STAT_NOTFOUND;
							state_q      <= S_FIN;
						end else begin
							cmp_v_q <= rd_more;
						end
					end
				end
				S_SHIFT: begin
					if (rd_more) begin
						rd_i_q <= rd_i_q + CW'(1);
					end
					wv_q <= rd_more;
					wj_q <= rd_i_q - CW'(1);
					if (!rd_more && !wv_q) begin
						count_q      <= count_q - CW'(1);
						res_status_q <= STAT_OK;
						state_q      <= S_FIN;
					end
				end
				S_FIN: begin
					if (out_free) begin
						out_status_q <= res_status_q;
						out_data_q   <= res_data_q;
						out_count_q  <= count_q;
						out_empty_q  <= (count_q == '0);
						state_q      <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule
